FILE: design/hmcp_pkg.sv
// Package for the hex monitor command parser core.
// Holds the character codes, result kinds, command modes and the hex digit decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hmcp_pkg;

	// Default memory size in bytes.
	localparam int MEMORY_BYTES_DEF = 65536;

	// Widths of the fixed item fields.
	localparam int ADDR_W = 16;
	localparam int CHAR_W = 8;
	localparam int DATA_W = 8;
	localparam int KIND_W = 2;

	// Character codes with a meaning of their own.
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CHAR_RUN   = 8'h72;

	// Result kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_BYTE    = 2'd0,
		KIND_ERROR   = 2'd1,
		KIND_REFUSED = 2'd2
	} kind_t;

	// Command mode, one-hot.
	typedef enum logic [3:0] {
		CMD_EXAMINE    = 4'b0001,
		CMD_BLOCK      = 4'b0010,
		CMD_STORE      = 4'b0100,
		CMD_ERROR_OWED = 4'b1000
	} cmd_mode_t;

	// Decoded hex digit.
	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_digit_t;

	// Lower-case hex digit decoder.
	function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
		hex_digit_t r;
		r.valid = 1'b0;
		r.value = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			r.valid = 1'b1;
			r.value = c[3:0];
		end else if (c inside {[8'h61:8'h66]}) begin
			r.valid = 1'b1;
			r.value = 4'(c[3:0] + 4'd9);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/hex_monitor_command_parser_core.sv
// Hex monitor command parser core: character parser, command state and byte memory.
// Depends on hmcp_pkg.
//
// Path: an accepted item passes the input register, then the result register, which
// drives the outputs and is loaded together with the registered memory read.
// Throughput: one item per cycle while the result side does not stall.
// Reset: control state clears at once; then a clearing pass zeroes the memory, one byte
// a cycle through every index, during which in_stall stays high.
`timescale 1ns / 1ps
`default_nettype none

module hex_monitor_command_parser_core #(
	parameter int MEMORY_BYTES = hmcp_pkg::MEMORY_BYTES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          mode,
	input  wire logic [hmcp_pkg::CHAR_W-1:0]   char_code,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [hmcp_pkg::KIND_W-1:0]        kind,
	output logic [hmcp_pkg::ADDR_W-1:0]        address,
	output logic [hmcp_pkg::DATA_W-1:0]        data,
	output logic                               new_row,
	output logic                               last
);

	import hmcp_pkg::*;

	localparam int AW = $clog2(MEMORY_BYTES);
	localparam int TW = AW + 4;
	localparam logic [TW-1:0] MEM_SIZE_T = TW'(MEMORY_BYTES);
	localparam logic [AW-1:0] MEM_TOP = AW'(MEMORY_BYTES - 1);
	// Weight of one unit of a nibble shifted out of the 16-bit number, modulo the memory size.
	localparam int DROP_UNIT = (1 << ADDR_W) % MEMORY_BYTES;

	// Increment of a memory index, wrapping at the memory size.
	function automatic logic [AW-1:0] inc_mod(input logic [AW-1:0] x);
		return (x == MEM_TOP) ? '0 : AW'(x + 1'b1);
	endfunction

	// Residue, modulo the memory size, of a nibble lost off the top of the number.
	function automatic logic [AW-1:0] drop_mod(input logic [3:0] top);
		logic [AW-1:0] o;
		int            acc;
		o   = '0;
		acc = 0;
		for (int j = 1; j < 16; j++) begin
			acc = acc + DROP_UNIT;
			if (acc >= MEMORY_BYTES) begin
				acc = acc - MEMORY_BYTES;
			end
			if (top == 4'(j)) begin
				o = AW'(acc);
			end
		end
		return o;
	endfunction

	// Shifts a hex digit into a value held modulo the memory size, taking off the part
	// of the nibble that drops out of the 16-bit number.
	function automatic logic [AW-1:0] shift_mod(input logic [AW-1:0] r,
			input logic [3:0] d, input logic [3:0] top);
		logic [TW-1:0] t;
		logic [AW-1:0] o;
		t = {r, d};
		for (int k = 3; k >= 0; k--) begin
			if (t >= (MEM_SIZE_T << k)) begin
				t = t - (MEM_SIZE_T << k);
			end
		end
		o = drop_mod(top);
		if (t[AW-1:0] < o) begin
			t = t + MEM_SIZE_T - {4'd0, o};
		end else begin
			t = t - {4'd0, o};
		end
		return t[AW-1:0];
	endfunction

	// Memory and its clearing pass.
	logic [DATA_W-1:0] mem [MEMORY_BYTES];
	logic              clr_q;
	logic [AW-1:0]     clr_idx_q;

	// Input register.
	logic              valid_s1;
	logic              mode_s1;
	logic [CHAR_W-1:0] char_s1;

	// Result register.
	logic              valid_s2;
	kind_t             kind_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic              row_s2;
	logic              last_s2;
	logic [DATA_W-1:0] rd_s2;

	// Command state.
	logic [ADDR_W-1:0] store_addr_q;
	logic [AW-1:0]     store_mod_q;
	logic [ADDR_W-1:0] exam_addr_q;
	logic [AW-1:0]     exam_mod_q;
	cmd_mode_t         cmd_q;
	logic [ADDR_W-1:0] num_q;
	logic [AW-1:0]     num_mod_q;
	logic              digit_seen_q;
	logic              skip_q;
	logic [ADDR_W-1:0] dump_end_q;
	logic              dump_pending_q;

	// Next state and result of the item in the input register.
	logic [ADDR_W-1:0] store_addr_d;
	logic [AW-1:0]     store_mod_d;
	logic [ADDR_W-1:0] exam_addr_d;
	logic [AW-1:0]     exam_mod_d;
	cmd_mode_t         cmd_d;
	cmd_mode_t         cmd_mid;
	logic [ADDR_W-1:0] num_d;
	logic [AW-1:0]     num_mod_d;
	logic              digit_seen_d;
	logic              skip_d;
	logic [ADDR_W-1:0] dump_end_d;
	logic              dump_pending_d;
	logic [ADDR_W-1:0] exam_inc;
	logic [AW-1:0]     exam_mod_inc;
	hex_digit_t        digit;
	logic              shown;
	logic              res_valid;
	kind_t             res_kind;
	logic [ADDR_W-1:0] res_addr;
	logic              res_row;
	logic              res_last;
	logic              rd_en;
	logic [AW-1:0]     rd_idx;
	logic              st_we;

	logic              adv_ok;
	logic              fire;
	logic              accept;
	logic              mem_we;
	logic [AW-1:0]     mem_widx;
	logic [DATA_W-1:0] mem_wdata;

	// Handshake: the input register moves on when the result register is empty or its result is taken.
	assign adv_ok   = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && adv_ok;
	assign in_stall = clr_q || (valid_s1 && !adv_ok);
	assign accept   = in_valid && !in_stall;

	// Parser: works out the effect of one item on the command state.
	always_comb begin
		store_addr_d   = store_addr_q;
		store_mod_d    = store_mod_q;
		exam_addr_d    = exam_addr_q;
		exam_mod_d     = exam_mod_q;
		cmd_d          = cmd_q;
		cmd_mid        = cmd_q;
		num_d          = num_q;
		num_mod_d      = num_mod_q;
		digit_seen_d   = digit_seen_q;
		skip_d         = skip_q;
		dump_end_d     = dump_end_q;
		dump_pending_d = dump_pending_q;
		exam_inc       = ADDR_W'(exam_addr_q + 1'b1);
		exam_mod_inc   = inc_mod(exam_mod_q);
		digit          = hex_decode(char_s1);
		shown          = 1'b0;
		res_valid      = 1'b0;
		res_kind       = KIND_BYTE;
		res_addr       = '0;
		res_row        = 1'b0;
		res_last       = 1'b0;
		rd_en          = 1'b0;
		rd_idx         = exam_mod_inc;
		st_we          = 1'b0;

		if (mode_s1) begin
			// Advance item: next dump byte, else an owed error prompt.
			if (dump_pending_q) begin
				exam_addr_d    = exam_inc;
				exam_mod_d     = exam_mod_inc;
				dump_pending_d = (exam_inc != dump_end_q);
				res_valid      = 1'b1;
				res_addr       = exam_inc;
				res_row        = (exam_inc[2:0] == 3'd0);
				res_last       = !dump_pending_d && (cmd_q != CMD_ERROR_OWED);
				rd_en          = 1'b1;
			end else if (cmd_q == CMD_ERROR_OWED) begin
				cmd_d     = CMD_EXAMINE;
				res_valid = 1'b1;
				res_kind  = KIND_ERROR;
				res_last  = 1'b1;
			end
		end else if (dump_pending_q || cmd_q == CMD_ERROR_OWED) begin
			// A character while output is still owed is refused.
			res_valid = 1'b1;
			res_kind  = KIND_REFUSED;
		end else if (skip_q) begin
			// Skipped line: only a line feed ends it.
			if (char_s1 == CHAR_LF) begin
				skip_d       = 1'b0;
				cmd_d        = CMD_EXAMINE;
				digit_seen_d = 1'b0;
				num_d        = '0;
				num_mod_d    = '0;
			end
		end else if (digit.valid) begin
			num_d        = {num_q[ADDR_W-5:0], digit.value};
			num_mod_d    = shift_mod(num_mod_q, digit.value, num_q[ADDR_W-1:ADDR_W-4]);
			digit_seen_d = 1'b1;
		end else begin
			// A non-digit ends the pending number, which is acted on first.
			if (digit_seen_q) begin
				digit_seen_d = 1'b0;
				num_d        = '0;
				num_mod_d    = '0;
				if (cmd_q == CMD_STORE) begin
					st_we        = 1'b1;
					store_addr_d = ADDR_W'(store_addr_q + 1'b1);
					store_mod_d  = (&store_addr_q) ? '0 : inc_mod(store_mod_q);
				end else if (cmd_q == CMD_EXAMINE) begin
					store_addr_d = num_q;
					store_mod_d  = num_mod_q;
					exam_addr_d  = num_q;
					exam_mod_d   = num_mod_q;
					shown        = 1'b1;
					res_valid    = 1'b1;
					res_addr     = num_q;
					res_row      = 1'b1;
					res_last     = 1'b1;
					rd_en        = 1'b1;
					rd_idx       = num_mod_q;
				end else begin
					if (exam_addr_q < num_q) begin
						exam_addr_d    = exam_inc;
						exam_mod_d     = exam_mod_inc;
						dump_end_d     = num_q;
						dump_pending_d = (exam_inc != num_q);
						shown          = 1'b1;
						res_valid      = 1'b1;
						res_addr       = exam_inc;
						res_row        = (exam_inc[2:0] == 3'd0);
						res_last       = !dump_pending_d;
						rd_en          = 1'b1;
					end
					cmd_mid = CMD_EXAMINE;
				end
				cmd_d = cmd_mid;
			end

			// Then the character itself takes effect.
			if (char_s1 == CHAR_LF) begin
				cmd_d = CMD_EXAMINE;
			end else if (char_s1 < CHAR_DOT || char_s1[CHAR_W-1]) begin
				cmd_d = cmd_mid;
			end else if (char_s1 == CHAR_DOT) begin
				cmd_d = CMD_BLOCK;
			end else if (char_s1 == CHAR_COLON) begin
				cmd_d = CMD_STORE;
			end else if (char_s1 == CHAR_RUN) begin
				skip_d = 1'b1;
			end else begin
				// Syntax error: prompt now, or after the bytes just started.
				skip_d = 1'b1;
				if (shown) begin
					cmd_d    = CMD_ERROR_OWED;
					res_last = 1'b0;
				end else begin
					cmd_d     = CMD_EXAMINE;
					res_valid = 1'b1;
					res_kind  = KIND_ERROR;
					res_addr  = '0;
					res_row   = 1'b0;
					res_last  = 1'b1;
				end
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_ok) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			char_s1 <= char_code;
		end
	end

	// Command state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_addr_q   <= '0;
			store_mod_q    <= '0;
			exam_addr_q    <= '0;
			exam_mod_q     <= '0;
			cmd_q          <= CMD_EXAMINE;
			num_q          <= '0;
			num_mod_q      <= '0;
			digit_seen_q   <= 1'b0;
			skip_q         <= 1'b0;
			dump_end_q     <= '0;
			dump_pending_q <= 1'b0;
		end else if (fire) begin
			store_addr_q   <= store_addr_d;
			store_mod_q    <= store_mod_d;
			exam_addr_q    <= exam_addr_d;
			exam_mod_q     <= exam_mod_d;
			cmd_q          <= cmd_d;
			num_q          <= num_d;
			num_mod_q      <= num_mod_d;
			digit_seen_q   <= digit_seen_d;
			skip_q         <= skip_d;
			dump_end_q     <= dump_end_d;
			dump_pending_q <= dump_pending_d;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_ok) begin
			valid_s2 <= valid_s1 && res_valid;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			kind_s2 <= res_kind;
			addr_s2 <= res_addr;
			row_s2  <= res_row;
			last_s2 <= res_last;
		end
	end

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			if (clr_idx_q == MEM_TOP) begin
				clr_q <= 1'b0;
			end else begin
				clr_idx_q <= AW'(clr_idx_q + 1'b1);
			end
		end
	end

	// Memory write port: clearing pass or store command.
	assign mem_we    = clr_q || (fire && st_we);
	assign mem_widx  = clr_q ? clr_idx_q : store_mod_q;
	assign mem_wdata = clr_q ? '0 : num_q[DATA_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_widx] <= mem_wdata;
		end
	end

	// Memory read port, registered with the result.
	always_ff @(posedge clk) begin
		if (fire && rd_en) begin
			rd_s2 <= mem[rd_idx];
		end
	end

	// Outputs.
	assign out_valid = valid_s2;
	assign kind      = kind_s2;
	assign address   = addr_s2;
	assign new_row   = row_s2;
	assign last      = last_s2;
	assign data      = (kind_s2 == KIND_BYTE) ? rd_s2 : '0;

endmodule

`default_nettype wire
